[design/hhdc_pkg.sv]
// hhdc_pkg: shared codes and constants of the heading hold drive controller
// no dependencies; used by the controller and its port checker
`timescale 1ns / 1ps
`default_nettype none

package hhdc_pkg;

    // command codes carried in the slave-side tuser
    typedef enum logic [2:0] {
        OP_STOP     = 3'd0,
        OP_FORWARD  = 3'd1,
        OP_BACKWARD = 3'd2,
        OP_RIGHT    = 3'd3,
        OP_LEFT     = 3'd4,
        OP_SAMPLE   = 3'd5,
        OP_SET_SPD  = 3'd6
    } t_op;

    // motion codes reported on the master side
    typedef enum logic [2:0] {
        MOT_STOP     = 3'd0,
        MOT_FORWARD  = 3'd1,
        MOT_BACKWARD = 3'd2,
        MOT_RIGHT    = 3'd3,
        MOT_LEFT     = 3'd4
    } t_motion;

    // wheel select codes of the set speed command
    typedef enum logic [1:0] {
        SEL_RIGHT = 2'd0,
        SEL_LEFT  = 2'd1,
        SEL_BOTH  = 2'd2
    } t_sel;

    // configuration register indexes
    localparam logic CFG_MIN_DUTY = 1'b0;
    localparam logic CFG_MAX_DUTY = 1'b1;

    localparam int DECAY_TABLE_SIZE_DEF = 1024;
    localparam int PWM_BITS_DEF         = 12;

    localparam int HDG_W = 16;
    localparam int OP_W  = 3;
    localparam int SEL_W = 2;
    localparam int MOT_W = 3;

    localparam int unsigned MIN_DUTY_RST = 150;
    localparam int unsigned MAX_DUTY_RST = 4095;

    // 0.35777^(1/100) in Q0.32
    localparam logic [63:0] STEP_RATIO = 64'd4251046938;

endpackage

`default_nettype wire

[design/heading_hold_drive_controller.sv]
// heading_hold_drive_controller: two-wheel drive command decoder with heading hold
// uses hhdc_pkg; decay factor rom built at elaboration inside this module
//
// One command word in, one duty word out. The block takes a word in every cycle
// unless the output stalls on i_m_tready. The command is decoded and the heading
// error formed in the accepting cycle, then comes the registered read of the decay
// rom, then the multiply and the wheel speed update into the output register.
// Motion, hold and goal heading are updated at acceptance; wheel speeds are kept
// at the output stage, so back-to-back samples need no stall. Config writes
// (min_duty index 0, max_duty index 1) must come while no word is in flight.
`timescale 1ns / 1ps
`default_nettype none

module heading_hold_drive_controller #(
    parameter  int DECAY_TABLE_SIZE = hhdc_pkg::DECAY_TABLE_SIZE_DEF,
    parameter  int PWM_BITS         = hhdc_pkg::PWM_BITS_DEF,
    localparam int IN_RAW_W  = hhdc_pkg::HDG_W + 1 + PWM_BITS,
    localparam int IN_DATA_W = ((IN_RAW_W + 7) / 8) * 8,
    localparam int IN_USER_W = 8,
    localparam int OUT_RAW_W = 4 * PWM_BITS + hhdc_pkg::MOT_W + 1 + hhdc_pkg::HDG_W,
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // heading[15:0], pivot, speed, zero pad
    input  wire  [IN_DATA_W-1:0]  i_s_tdata,
    // opcode[2:0], wheel_select[4:3], zero pad
    input  wire  [IN_USER_W-1:0]  i_s_tuser,
    input  wire                   i_s_tvalid,
    output logic                  o_s_tready,
    // right_fwd_duty, right_rev_duty, left_fwd_duty, left_rev_duty,
    // motion, holding, goal_heading, zero pad
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tvalid,
    input  wire                   i_m_tready,
    input  wire                   i_cfg_we,
    input  wire                   i_cfg_index,
    input  wire  [PWM_BITS-1:0]   i_cfg_data
);

    localparam int HW = hhdc_pkg::HDG_W;
    localparam int AW = $clog2(DECAY_TABLE_SIZE);
    localparam int MW = HW + 1;

    typedef logic [15:0] t_rom [DECAY_TABLE_SIZE];

    typedef struct packed {
        hhdc_pkg::t_op     op;
        logic [PWM_BITS-1:0] spd;
        hhdc_pkg::t_sel    sel;
        logic              samp;
        logic              neg;
        logic              inr;
        logic [AW-1:0]     addr;
        hhdc_pkg::t_motion motion;
        logic              hold;
        logic [HW-1:0]     goal;
        logic              piv;
    } t_item;

    function automatic t_rom rom_fill();
        t_rom        rom;
        logic [63:0] q;
        logic [63:0] e;
        q = 64'h1_0000_0000;
        for (int i = 0; i < DECAY_TABLE_SIZE; i++) begin
            e = (q + 64'd32768) >> 16;
            rom[i] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
            q = (q * hhdc_pkg::STEP_RATIO + 64'h8000_0000) >> 32;
        end
        return rom;
    endfunction

    localparam t_rom DecayRom = rom_fill();

    // configuration
    logic [PWM_BITS-1:0] r_min_duty;
    logic [PWM_BITS-1:0] r_max_duty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_duty <= PWM_BITS'(hhdc_pkg::MIN_DUTY_RST);
            r_max_duty <= PWM_BITS'(hhdc_pkg::MAX_DUTY_RST);
        end else if (i_cfg_we) begin
            if (i_cfg_index == hhdc_pkg::CFG_MIN_DUTY) begin
                r_min_duty <= i_cfg_data;
            end else begin
                r_max_duty <= i_cfg_data;
            end
        end
    end

    // input word fields
    hhdc_pkg::t_op       w_op;
    hhdc_pkg::t_sel      w_sel;
    logic [HW-1:0]       w_hdg;
    logic                w_piv;
    logic [PWM_BITS-1:0] w_spd;

    assign w_op  = hhdc_pkg::t_op'(i_s_tuser[2:0]);
    assign w_sel = hhdc_pkg::t_sel'(i_s_tuser[4:3]);
    assign w_hdg = i_s_tdata[HW-1:0];
    assign w_piv = i_s_tdata[HW];
    assign w_spd = i_s_tdata[HW+PWM_BITS:HW+1];

    // pipeline flow
    logic r_s1_v, r_s2_v, r_ov;
    logic w_adv1, w_adv2, w_adv_out, w_acc;

    assign w_adv_out  = !r_ov || i_m_tready;
    assign w_adv2     = !r_s2_v || w_adv_out;
    assign w_adv1     = !r_s1_v || w_adv2;
    assign o_s_tready = w_adv1;
    assign w_acc      = i_s_tvalid && w_adv1;

    // front state: motion, hold, heading, direction, pivot
    hhdc_pkg::t_motion r_motion, n_motion;
    logic              r_hold, n_hold;
    logic [HW-1:0]     r_held, n_held;
    logic              r_rev, n_rev;
    logic              r_piv, n_piv;

    always_comb begin
        n_motion = r_motion;
        n_hold   = r_hold;
        n_held   = r_held;
        n_rev    = r_rev;
        n_piv    = r_piv;
        case (w_op)
            hhdc_pkg::OP_STOP: begin
                n_hold   = 1'b0;
                n_motion = hhdc_pkg::MOT_STOP;
            end
            hhdc_pkg::OP_FORWARD, hhdc_pkg::OP_BACKWARD: begin
                n_held   = w_hdg;
                n_hold   = 1'b1;
                n_rev    = (w_op == hhdc_pkg::OP_BACKWARD);
                n_piv    = 1'b0;
                n_motion = (w_op == hhdc_pkg::OP_BACKWARD) ? hhdc_pkg::MOT_BACKWARD
                                                           : hhdc_pkg::MOT_FORWARD;
            end
            hhdc_pkg::OP_RIGHT: begin
                n_piv    = w_piv;
                n_hold   = 1'b0;
                n_motion = hhdc_pkg::MOT_RIGHT;
            end
            hhdc_pkg::OP_LEFT: begin
                n_piv    = w_piv;
                n_hold   = 1'b0;
                n_motion = hhdc_pkg::MOT_LEFT;
            end
            default: begin
            end
        endcase
    end

    // heading error, not wrapped at the half turn
    logic signed [MW:0]  w_err;
    logic signed [MW:0]  w_err_dir;
    logic [MW-1:0]       w_mag;
    logic                w_inr;
    t_item               w_item;

    assign w_err     = (MW+1)'(signed'(w_hdg)) - (MW+1)'(signed'(r_held));
    assign w_err_dir = r_rev ? -w_err : w_err;
    assign w_mag     = w_err_dir[MW] ? MW'(-w_err_dir) : MW'(w_err_dir);
    assign w_inr     = w_mag < MW'(DECAY_TABLE_SIZE);

    always_comb begin
        w_item.op     = w_op;
        w_item.spd    = w_spd;
        w_item.sel    = w_sel;
        w_item.samp   = (w_op == hhdc_pkg::OP_SAMPLE) && r_hold;
        w_item.neg    = w_err_dir[MW];
        w_item.inr    = w_inr;
        w_item.addr   = w_inr ? w_mag[AW-1:0] : '0;
        w_item.motion = n_motion;
        w_item.hold   = n_hold;
        w_item.goal   = n_held;
        w_item.piv    = n_piv;
    end

    t_item       r_s1_item, r_s2_item;
    logic [15:0] r_s2_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion <= hhdc_pkg::MOT_STOP;
            r_hold   <= 1'b0;
            r_held   <= '0;
            r_rev    <= 1'b0;
            r_piv    <= 1'b0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
        end else begin
            if (w_acc) begin
                r_motion <= n_motion;
                r_hold   <= n_hold;
                r_held   <= n_held;
                r_rev    <= n_rev;
                r_piv    <= n_piv;
            end
            if (w_adv1) begin
                r_s1_v <= w_acc;
            end
            if (w_adv2) begin
                r_s2_v <= r_s1_v;
            end
        end
    end

    // payload stages and registered rom read
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_item <= w_item;
        end
        if (w_adv2 && r_s1_v) begin
            r_s2_item  <= r_s1_item;
            r_s2_entry <= DecayRom[r_s1_item.addr];
        end
    end

    // slowed duty: lo + range * factor
    logic [PWM_BITS-1:0] w_lo, w_range, w_slow;
    logic [PWM_BITS+16:0] w_prod;

    assign w_lo    = (r_min_duty < r_max_duty) ? r_min_duty : r_max_duty;
    assign w_range = r_max_duty - w_lo;
    assign w_prod  = (PWM_BITS+17)'(w_range) * (PWM_BITS+17)'(r_s2_entry)
                   + (PWM_BITS+17)'(32768);
    assign w_slow  = r_s2_item.inr ? (w_lo + w_prod[PWM_BITS+15:16]) : w_lo;

    // wheel speeds, kept at the output stage
    logic [PWM_BITS-1:0] r_rspd, n_rspd;
    logic [PWM_BITS-1:0] r_lspd, n_lspd;

    always_comb begin
        n_rspd = r_rspd;
        n_lspd = r_lspd;
        case (r_s2_item.op)
            hhdc_pkg::OP_FORWARD, hhdc_pkg::OP_BACKWARD: begin
                n_rspd = r_max_duty;
                n_lspd = r_max_duty;
            end
            hhdc_pkg::OP_RIGHT: begin
                n_rspd = r_s2_item.piv ? '0 : r_max_duty;
                n_lspd = r_max_duty;
            end
            hhdc_pkg::OP_LEFT: begin
                n_lspd = r_s2_item.piv ? '0 : r_max_duty;
                n_rspd = r_max_duty;
            end
            hhdc_pkg::OP_SAMPLE: begin
                if (r_s2_item.samp) begin
                    if (r_s2_item.neg) begin
                        n_lspd = w_slow;
                        n_rspd = r_max_duty;
                    end else begin
                        n_rspd = w_slow;
                        n_lspd = r_max_duty;
                    end
                end
            end
            hhdc_pkg::OP_SET_SPD: begin
                if (r_s2_item.sel == hhdc_pkg::SEL_RIGHT
                        || r_s2_item.sel == hhdc_pkg::SEL_BOTH) begin
                    n_rspd = r_s2_item.spd;
                end
                if (r_s2_item.sel == hhdc_pkg::SEL_LEFT
                        || r_s2_item.sel == hhdc_pkg::SEL_BOTH) begin
                    n_lspd = r_s2_item.spd;
                end
            end
            default: begin
            end
        endcase
    end

    // bridge leg duties from motion and new speeds
    logic [PWM_BITS-1:0] w_rf, w_rr, w_lf, w_lr;

    always_comb begin
        w_rf = '0;
        w_rr = '0;
        w_lf = '0;
        w_lr = '0;
        case (r_s2_item.motion)
            hhdc_pkg::MOT_FORWARD: begin
                w_rf = n_rspd;
                w_lf = n_lspd;
            end
            hhdc_pkg::MOT_BACKWARD: begin
                w_rr = n_rspd;
                w_lr = n_lspd;
            end
            hhdc_pkg::MOT_RIGHT: begin
                w_lf = n_lspd;
                w_rr = r_s2_item.piv ? '0 : n_rspd;
            end
            hhdc_pkg::MOT_LEFT: begin
                w_rf = n_rspd;
                w_lr = r_s2_item.piv ? '0 : n_lspd;
            end
            default: begin
            end
        endcase
    end

    logic w_load_out;
    assign w_load_out = w_adv_out && r_s2_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_rspd <= PWM_BITS'(hhdc_pkg::MAX_DUTY_RST);
            r_lspd <= PWM_BITS'(hhdc_pkg::MAX_DUTY_RST);
        end else begin
            if (w_adv_out) begin
                r_ov <= r_s2_v;
            end
            if (w_load_out) begin
                r_rspd <= n_rspd;
                r_lspd <= n_lspd;
            end
        end
    end

    logic [OUT_DATA_W-1:0] r_mdata;

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_mdata <= OUT_DATA_W'({r_s2_item.goal, r_s2_item.hold, r_s2_item.motion,
                                    w_lr, w_lf, w_rr, w_rf});
        end
    end

    assign o_m_tdata  = r_mdata;
    assign o_m_tvalid = r_ov;

endmodule

`default_nettype wire

[design/hhdc_port_checker.sv]
// hhdc_port_checker: port-level checks of the heading hold drive controller
// uses hhdc_pkg; bound to heading_hold_drive_controller at the end of this file
`timescale 1ns / 1ps
`default_nettype none

module hhdc_port_checker #(
    parameter  int PWM_BITS   = hhdc_pkg::PWM_BITS_DEF,
    localparam int OUT_RAW_W  = 4 * PWM_BITS + hhdc_pkg::MOT_W + 1 + hhdc_pkg::HDG_W,
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8
) (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire [OUT_DATA_W-1:0] i_m_tdata,
    input wire                  i_m_tvalid,
    input wire                  i_m_tready
);

    localparam int P = PWM_BITS;

    logic [P-1:0] w_rf, w_rr, w_lf, w_lr;
    logic [2:0]   w_mot;
    logic         w_hold;

    assign w_rf   = i_m_tdata[P-1:0];
    assign w_rr   = i_m_tdata[2*P-1:P];
    assign w_lf   = i_m_tdata[3*P-1:2*P];
    assign w_lr   = i_m_tdata[4*P-1:3*P];
    assign w_mot  = i_m_tdata[4*P+2:4*P];
    assign w_hold = i_m_tdata[4*P+3];

    // hold only runs while driving straight
    a_hold_straight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && w_hold |->
            (w_mot == hhdc_pkg::MOT_FORWARD || w_mot == hhdc_pkg::MOT_BACKWARD))
        else $error("hold reported outside straight travel");

    // stopped means every bridge leg off
    a_stop_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && w_mot == hhdc_pkg::MOT_STOP |->
            (w_rf == '0 && w_rr == '0 && w_lf == '0 && w_lr == '0))
        else $error("duty driven while stopped");

    // straight travel never drives both legs of one bridge
    a_no_shoot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (w_mot == hhdc_pkg::MOT_FORWARD || w_mot == hhdc_pkg::MOT_BACKWARD) |->
            (w_rr == '0 && w_lr == '0) || (w_rf == '0 && w_lf == '0))
        else $error("both legs of a bridge driven");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("output word dropped or changed while stalled");

endmodule

bind heading_hold_drive_controller hhdc_port_checker #(
    .PWM_BITS(PWM_BITS)
) u_hhdc_port_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tdata  (o_m_tdata),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);

`default_nettype wire

[dv/testbench.sv]
// testbench: self-checking bench for heading_hold_drive_controller
// depends on hhdc_pkg and the controller rtl; a scoreboard class predicts every duty word
`timescale 1ns / 1ps

module testbench;

    localparam int IN_DATA_W       = 32;
    localparam int OUT_DATA_W      = 72;
    localparam int TABLE_DEPTH     = hhdc_pkg::DECAY_TABLE_SIZE_DEF;
    localparam int ITEMS_PER_PHASE = 315;
    localparam int NUM_PHASES      = 6;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HDG_LIMIT       = 18000;

    // codes outside the defined sets, still legal on the wires
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam logic [1:0] SEL_NONE  = 2'd3;

    typedef struct {
        logic [2:0]         opcode;
        logic signed [15:0] heading;
        logic               pivot;
        logic [11:0]        speed;
        logic [1:0]         sel;
    } t_drive_cmd;

    typedef struct {
        logic [11:0]        rf;
        logic [11:0]        rr;
        logic [11:0]        lf;
        logic [11:0]        lr;
        logic [2:0]         motion;
        logic               holding;
        logic signed [15:0] goal;
    } t_duty_word;

    class duty_tracker;
        bit [15:0]          decay_q16 [TABLE_DEPTH];
        logic [11:0]        min_duty;
        logic [11:0]        max_duty;
        logic [11:0]        lwheel_duty;
        logic [11:0]        rwheel_duty;
        logic signed [15:0] held_hdg;
        bit                 hold_on;
        bit                 reversing;
        bit                 pivoting;
        hhdc_pkg::t_motion  motion;
        t_duty_word         expected_duties [$];
        int                 errors;
        int                 n_commands;
        int                 n_effective;
        int                 n_words;
        int                 n_table_hits;

        function new();
            bit [63:0] q;
            bit [63:0] e;
            q = 64'd1 << 32;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                e = (q + 64'd32768) >> 16;
                decay_q16[i] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
                q = (q * hhdc_pkg::STEP_RATIO + (64'd1 << 31)) >> 32;
            end
            min_duty    = 12'(hhdc_pkg::MIN_DUTY_RST);
            max_duty    = 12'(hhdc_pkg::MAX_DUTY_RST);
            lwheel_duty = max_duty;
            rwheel_duty = max_duty;
            held_hdg    = '0;
            hold_on     = 1'b0;
            reversing   = 1'b0;
            pivoting    = 1'b0;
            motion      = hhdc_pkg::MOT_STOP;
        endfunction

        function void set_duty_limits(logic [11:0] lo_val, logic [11:0] hi_val);
            min_duty = lo_val;
            max_duty = hi_val;
        endfunction

        // slowed wheel duty for a heading error magnitude
        function logic [11:0] corrected_duty(int unsigned mag);
            int unsigned lo;
            int unsigned span;
            lo   = (min_duty < max_duty) ? min_duty : max_duty;
            span = max_duty - lo;
            if (mag >= TABLE_DEPTH) return 12'(lo);
            n_table_hits++;
            return 12'(lo + ((span * decay_q16[mag] + 32'd32768) >> 16));
        endfunction

        function void note_command(t_drive_cmd c);
            t_duty_word w;
            int         err;
            bit         effective;
            effective = 1'b1;
            case (c.opcode)
                hhdc_pkg::OP_STOP: begin
                    hold_on = 1'b0;
                    motion  = hhdc_pkg::MOT_STOP;
                end
                hhdc_pkg::OP_FORWARD, hhdc_pkg::OP_BACKWARD: begin
                    lwheel_duty = max_duty;
                    rwheel_duty = max_duty;
                    held_hdg    = c.heading;
                    hold_on     = 1'b1;
                    reversing   = (c.opcode == hhdc_pkg::OP_BACKWARD);
                    pivoting    = 1'b0;
                    motion      = (c.opcode == hhdc_pkg::OP_FORWARD)
                                ? hhdc_pkg::MOT_FORWARD : hhdc_pkg::MOT_BACKWARD;
                end
                hhdc_pkg::OP_RIGHT: begin
                    rwheel_duty = c.pivot ? 12'd0 : max_duty;
                    lwheel_duty = max_duty;
                    pivoting    = c.pivot;
                    hold_on     = 1'b0;
                    motion      = hhdc_pkg::MOT_RIGHT;
                end
                hhdc_pkg::OP_LEFT: begin
                    lwheel_duty = c.pivot ? 12'd0 : max_duty;
                    rwheel_duty = max_duty;
                    pivoting    = c.pivot;
                    hold_on     = 1'b0;
                    motion      = hhdc_pkg::MOT_LEFT;
                end
                hhdc_pkg::OP_SAMPLE: begin
                    if (hold_on) begin
                        // no wrap at +-180 degrees
                        err = int'(c.heading) - int'(held_hdg);
                        if (reversing) err = -err;
                        if (err < 0) begin
                            lwheel_duty = corrected_duty(-err);
                            rwheel_duty = max_duty;
                        end else begin
                            rwheel_duty = corrected_duty(err);
                            lwheel_duty = max_duty;
                        end
                    end else begin
                        effective = 1'b0;
                    end
                end
                hhdc_pkg::OP_SET_SPD: begin
                    if (c.sel == hhdc_pkg::SEL_RIGHT || c.sel == hhdc_pkg::SEL_BOTH)
                        rwheel_duty = c.speed;
                    if (c.sel == hhdc_pkg::SEL_LEFT || c.sel == hhdc_pkg::SEL_BOTH)
                        lwheel_duty = c.speed;
                    if (c.sel == SEL_NONE) effective = 1'b0;
                end
                default: begin
                    effective = 1'b0;
                end
            endcase

            w.rf = '0;
            w.rr = '0;
            w.lf = '0;
            w.lr = '0;
            case (motion)
                hhdc_pkg::MOT_FORWARD: begin
                    w.rf = rwheel_duty;
                    w.lf = lwheel_duty;
                end
                hhdc_pkg::MOT_BACKWARD: begin
                    w.rr = rwheel_duty;
                    w.lr = lwheel_duty;
                end
                hhdc_pkg::MOT_RIGHT: begin
                    w.lf = lwheel_duty;
                    w.rr = pivoting ? 12'd0 : rwheel_duty;
                end
                hhdc_pkg::MOT_LEFT: begin
                    w.rf = rwheel_duty;
                    w.lr = pivoting ? 12'd0 : lwheel_duty;
                end
                default: ;
            endcase
            w.motion  = motion;
            w.holding = hold_on;
            w.goal    = held_hdg;
            expected_duties = {expected_duties, w};
            n_commands++;
            if (effective) n_effective++;
        endfunction

        function void compare_field(string name, int exp_val, int act_val);
            if (exp_val != act_val) begin
                $error("%s: expected %0d, got %0d", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_duty_word(logic [OUT_DATA_W-1:0] d);
            t_duty_word e;
            if (expected_duties.size() == 0) begin
                $error("duty word with nothing expected: %h", d);
                errors++;
                return;
            end
            e = expected_duties.pop_front();
            n_words++;
            compare_field("right_fwd_duty", int'(e.rf), int'(d[11:0]));
            compare_field("right_rev_duty", int'(e.rr), int'(d[23:12]));
            compare_field("left_fwd_duty", int'(e.lf), int'(d[35:24]));
            compare_field("left_rev_duty", int'(e.lr), int'(d[47:36]));
            compare_field("motion", int'(e.motion), int'(d[50:48]));
            compare_field("holding", int'(e.holding), int'(d[51]));
            compare_field("goal_heading", int'(e.goal), int'($signed(d[67:52])));
        endfunction

        function int pending();
            return expected_duties.size();
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [7:0]            s_tuser   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_index = 1'b0;
    logic [11:0]           cfg_data  = '0;

    duty_tracker sb;
    int send_idle_pct = 27;
    int recv_idle_pct = 57;
    int quiet_cycles  = 0;
    int n_settings    = 1;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    heading_hold_drive_controller u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always @(negedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result check and watchdog on stalled traffic
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_tvalid && m_tready) sb.check_duty_word(m_tdata);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("watchdog: no word moved for %0d cycles", quiet_cycles);
                    $display("TEST FAILED");
                    $finish;
                end
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_command(input t_drive_cmd c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= 8'($urandom);
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, c.speed, c.pivot, c.heading};
        s_tuser  <= {3'b000, c.sel, c.opcode};
        do @(posedge clk); while (!s_tready);
        sb.note_command(c);
        @(negedge clk);
    endtask

    task automatic send_fields(input logic [2:0] op, input int hdg, input logic piv,
                               input logic [11:0] spd, input logic [1:0] sel);
        t_drive_cmd c;
        c.opcode  = op;
        c.heading = 16'(hdg);
        c.pivot   = piv;
        c.speed   = spd;
        c.sel     = sel;
        send_command(c);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0) @(negedge clk);
    endtask

    task automatic program_duties(input logic [11:0] lo_val, input logic [11:0] hi_val);
        cfg_we    <= 1'b1;
        cfg_index <= hhdc_pkg::CFG_MIN_DUTY;
        cfg_data  <= lo_val;
        @(negedge clk);
        cfg_index <= hhdc_pkg::CFG_MAX_DUTY;
        cfg_data  <= hi_val;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_duty_limits(lo_val, hi_val);
        n_settings++;
        @(negedge clk);
    endtask

    function automatic t_drive_cmd random_command();
        t_drive_cmd c;
        c.opcode  = 3'($urandom_range(7));
        c.heading = 16'(int'($urandom_range(2 * HDG_LIMIT)) - HDG_LIMIT);
        c.pivot   = 1'($urandom_range(1));
        c.speed   = 12'($urandom_range(4095));
        c.sel     = 2'($urandom_range(3));
        return c;
    endfunction

    // heading sample close to the held heading so the decay table gets used
    function automatic t_drive_cmd near_sample();
        t_drive_cmd c;
        int         r;
        int         h;
        c        = random_command();
        c.opcode = hhdc_pkg::OP_SAMPLE;
        r        = $urandom_range(99);
        if (r < 85) begin
            if (r < 70) h = int'(sb.held_hdg) + int'($urandom_range(2200)) - 1100;
            else h = int'(sb.held_hdg) + int'($urandom_range(40)) - 20;
            if (h > HDG_LIMIT) h = HDG_LIMIT;
            if (h < -HDG_LIMIT) h = -HDG_LIMIT;
            c.heading = 16'(h);
        end
        return c;
    endfunction

    task automatic hold_sequence();
        t_drive_cmd c;
        int         n;
        c        = random_command();
        c.opcode = $urandom_range(1) ? hhdc_pkg::OP_FORWARD : hhdc_pkg::OP_BACKWARD;
        send_command(c);
        n = $urandom_range(2, 10);
        repeat (n) begin
            if ($urandom_range(9) == 0) begin
                c        = random_command();
                c.opcode = hhdc_pkg::OP_SET_SPD;
                send_command(c);
            end
            send_command(near_sample());
        end
    endtask

    initial begin
        logic [11:0] lo_set [NUM_PHASES];
        logic [11:0] hi_set [NUM_PHASES];
        int          goal_count;

        lo_set = '{12'd0, 12'd4095, 12'd2000, 12'd4095, 12'd0, 12'd0};
        hi_set = '{12'd4095, 12'd0, 12'd1000, 12'd4095, 12'd0, 12'd0};
        lo_set[5] = 12'($urandom_range(4095));
        hi_set[5] = 12'($urandom_range(4095));

        sb = new();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed pass at reset limits
        send_fields(hhdc_pkg::OP_SAMPLE, 500, 1'b0, 12'd0, hhdc_pkg::SEL_RIGHT);
        send_fields(hhdc_pkg::OP_SET_SPD, 0, 1'b0, 12'd1234, hhdc_pkg::SEL_BOTH);
        send_fields(hhdc_pkg::OP_FORWARD, HDG_LIMIT, 1'b0, 12'd0, hhdc_pkg::SEL_RIGHT);
        send_fields(hhdc_pkg::OP_SAMPLE, HDG_LIMIT, 1'b0, 12'd0, hhdc_pkg::SEL_RIGHT);
        send_fields(hhdc_pkg::OP_SAMPLE, 17000, 1'b0, 12'd0, hhdc_pkg::SEL_RIGHT);
        send_fields(hhdc_pkg::OP_SAMPLE, HDG_LIMIT - 1023, 1'b0, 12'd0, hhdc_pkg::SEL_RIGHT);
        send_fields(hhdc_pkg::OP_SAMPLE, HDG_LIMIT - 1024, 1'b0, 12'd0, hhdc_pkg::SEL_RIGHT);
        send_fields(hhdc_pkg::OP_BACKWARD, -HDG_LIMIT, 1'b1, 12'd4095, SEL_NONE);
        send_fields(hhdc_pkg::OP_SAMPLE, -HDG_LIMIT + 500, 1'b0, 12'd0, hhdc_pkg::SEL_RIGHT);
        send_fields(hhdc_pkg::OP_SAMPLE, HDG_LIMIT, 1'b0, 12'd0, hhdc_pkg::SEL_RIGHT);
        send_fields(hhdc_pkg::OP_SET_SPD, 0, 1'b0, 12'd0, hhdc_pkg::SEL_RIGHT);
        send_fields(hhdc_pkg::OP_SET_SPD, 0, 1'b0, 12'd4095, hhdc_pkg::SEL_LEFT);
        send_fields(hhdc_pkg::OP_SET_SPD, 0, 1'b0, 12'd777, SEL_NONE);
        send_fields(hhdc_pkg::OP_RIGHT, 0, 1'b0, 12'd0, hhdc_pkg::SEL_RIGHT);
        send_fields(hhdc_pkg::OP_RIGHT, 0, 1'b1, 12'd0, hhdc_pkg::SEL_RIGHT);
        send_fields(hhdc_pkg::OP_LEFT, 0, 1'b0, 12'd0, hhdc_pkg::SEL_RIGHT);
        send_fields(hhdc_pkg::OP_LEFT, 0, 1'b1, 12'd0, hhdc_pkg::SEL_RIGHT);
        send_fields(hhdc_pkg::OP_SAMPLE, 100, 1'b0, 12'd0, hhdc_pkg::SEL_RIGHT);
        send_fields(OP_UNUSED, -1, 1'b1, 12'd4095, SEL_NONE);
        send_fields(hhdc_pkg::OP_SET_SPD, 0, 1'b0, 12'd2048, hhdc_pkg::SEL_BOTH);
        send_fields(hhdc_pkg::OP_FORWARD, 0, 1'b0, 12'd0, hhdc_pkg::SEL_RIGHT);
        send_fields(hhdc_pkg::OP_SAMPLE, 1, 1'b0, 12'd0, hhdc_pkg::SEL_RIGHT);
        send_fields(hhdc_pkg::OP_SAMPLE, -1, 1'b0, 12'd0, hhdc_pkg::SEL_RIGHT);
        send_fields(hhdc_pkg::OP_STOP, 0, 1'b0, 12'd0, hhdc_pkg::SEL_RIGHT);
        send_fields(hhdc_pkg::OP_SAMPLE, 0, 1'b0, 12'd0, hhdc_pkg::SEL_RIGHT);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase == 2) begin
                send_idle_pct = 57;
                recv_idle_pct = 27;
            end else if (phase == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // limits only change with the pipe empty
            wait_drained();
            repeat (4) @(negedge clk);
            program_duties(lo_set[phase], hi_set[phase]);
            goal_count = sb.n_effective + ITEMS_PER_PHASE;
            while (sb.n_effective < goal_count) begin
                if ($urandom_range(149) == 0) wait_drained();
                if ($urandom_range(99) < 55) hold_sequence();
                else send_command(random_command());
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.pending() != 0) begin
            $error("%0d duty words never arrived", sb.pending());
            sb.errors++;
        end

        $display("covered %0d commands and %0d duty words under %0d duty limit settings",
                 sb.n_commands, sb.n_words, n_settings);
        $display("%0d heading corrections read the decay table, %0d mismatches",
                 sb.n_table_hits, sb.errors);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
